>>> src/xrg_pkg.sv
package xrg_pkg;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

    localparam logic [255:0] SHORT_JUMP_POLY = {
        64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
        64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
    };
    localparam logic [255:0] FAR_JUMP_POLY = {
        64'h39109bb02acbe635, 64'h77710069854ee241,
        64'hc5004e441c522fb3, 64'h76e15d3efefdcbbf
    };

    localparam logic [2:0] OP_RAW    = 3'd0;
    localparam logic [2:0] OP_BOUND  = 3'd1;
    localparam logic [2:0] OP_FRAC   = 3'd2;
    localparam logic [2:0] OP_JUMP   = 3'd3;
    localparam logic [2:0] OP_LJUMP  = 3'd4;
    localparam logic [2:0] OP_RESEED = 3'd5;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_SEED_LOAD,
        CMD_CTR_ADV,
        CMD_MUL_LL,
        CMD_MUL_HL,
        CMD_MUL_LH,
        CMD_Z_MIX,
        CMD_STORE,
        CMD_STEP,
        CMD_ACC_CLR,
        CMD_ACC_COPY,
        CMD_BMUL,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_LOAD_OUT
    } dp_cmd_t;

    typedef enum logic [1:0] {
        OUT_RAW,
        OUT_FRAC,
        OUT_BND
    } out_kind_t;

    typedef struct packed {
        dp_cmd_t   cmd;
        logic      const_b;
        logic      acc_xor;
        out_kind_t kind;
    } dp_ctrl_t;

    typedef struct packed {
        logic range_zero;
        logic l_lt_range;
        logic l_lt_thr;
    } dp_stat_t;

    function automatic logic poly_bit(input logic far, input logic [7:0] idx);
        logic [255:0] p;
        p = far ? FAR_JUMP_POLY : SHORT_JUMP_POLY;
        return p[idx];
    endfunction

endpackage

>>> src/xrg_if.sv
interface xrg_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] low_bound;
    logic signed [31:0] high_bound;
    modport source (output valid, op, low_bound, high_bound, input ready);
    modport sink   (input valid, op, low_bound, high_bound, output ready);
endinterface

interface xrg_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        raw_or_fraction;
    logic signed [31:0] bounded_value;
    modport source (output valid, raw_or_fraction, bounded_value, input ready);
    modport sink   (input valid, raw_or_fraction, bounded_value, output ready);
endinterface

interface xrg_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> src/xrg_datapath.sv
module xrg_datapath
    import xrg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_ctrl_t           ctrl,
    input  logic               seed_we,
    input  logic [63:0]        seed_data,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output dp_stat_t           stat,
    output logic [63:0]        raw_or_fraction,
    output logic signed [31:0] bounded_value
);

    logic [63:0] seed_reg;
    logic [63:0] w_reg [4];
    logic [63:0] acc_reg [4];
    logic [63:0] ctr_reg;
    logic [63:0] z_reg;
    logic [63:0] macc_reg;
    logic [63:0] rnd_reg;
    logic [63:0] m_reg;
    logic [31:0] lo_reg;
    logic [31:0] range_reg;
    logic [31:0] rem_reg;
    logic [31:0] dq_reg;
    logic [63:0] out_raw_reg;
    logic [31:0] out_bnd_reg;

    logic [63:0] ctr_next;
    logic [63:0] mix_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] step_sum;
    logic [63:0] step_out;
    logic [63:0] n0, n1, n2, n3;
    logic [32:0] rem_shift;
    logic [31:0] bnd_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_data;
        end
    end

    assign ctr_next  = ctr_reg + GOLDEN_GAMMA;
    assign mix_const = ctrl.const_b ? MIX_MUL_B : MIX_MUL_A;

    always_comb
    begin
        mul_a = z_reg[31:0];
        mul_b = mix_const[31:0];
        case (ctrl.cmd)
            CMD_MUL_HL:
            begin
                mul_a = z_reg[63:32];
            end
            CMD_MUL_LH:
            begin
                mul_b = mix_const[63:32];
            end
            CMD_BMUL:
            begin
                mul_a = rnd_reg[63:32];
                mul_b = range_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    assign step_sum = w_reg[0] + w_reg[3];
    assign step_out = {step_sum[40:0], step_sum[63:41]};
    assign n2 = w_reg[2] ^ w_reg[0];
    assign n3 = w_reg[3] ^ w_reg[1];
    assign n1 = w_reg[1] ^ n2;
    assign n0 = w_reg[0] ^ n3;

    assign rem_shift = {rem_reg, dq_reg[31]};
    assign bnd_sum   = lo_reg + ((range_reg == 32'd0) ? rnd_reg[63:32] : m_reg[63:32]);

    always_ff @(posedge clk)
    begin
        case (ctrl.cmd)
            CMD_CAPTURE:
            begin
                lo_reg    <= low_bound;
                range_reg <= high_bound - low_bound + 32'd1;
            end
            CMD_SEED_LOAD:
            begin
                ctr_reg <= seed_reg;
            end
            CMD_CTR_ADV:
            begin
                ctr_reg <= ctr_next;
                z_reg   <= ctr_next ^ (ctr_next >> 30);
            end
            CMD_MUL_LL:
            begin
                macc_reg <= prod;
            end
            CMD_MUL_HL, CMD_MUL_LH:
            begin
                macc_reg <= macc_reg + {prod[31:0], 32'd0};
            end
            CMD_Z_MIX:
            begin
                z_reg <= macc_reg ^ (macc_reg >> 27);
            end
            CMD_STORE:
            begin
                w_reg[0] <= w_reg[1];
                w_reg[1] <= w_reg[2];
                w_reg[2] <= w_reg[3];
                w_reg[3] <= macc_reg ^ (macc_reg >> 31);
            end
            CMD_STEP:
            begin
                rnd_reg  <= step_out + w_reg[0];
                w_reg[0] <= n0;
                w_reg[1] <= n1;
                w_reg[2] <= n2 ^ (w_reg[1] << 17);
                w_reg[3] <= {n3[18:0], n3[63:19]};
                if (ctrl.acc_xor)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        acc_reg[k] <= acc_reg[k] ^ w_reg[k];
                    end
                end
            end
            CMD_ACC_CLR:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    acc_reg[k] <= '0;
                end
            end
            CMD_ACC_COPY:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    w_reg[k] <= acc_reg[k];
                end
            end
            CMD_BMUL:
            begin
                m_reg <= prod;
            end
            CMD_DIV_INIT:
            begin
                rem_reg <= '0;
                dq_reg  <= 32'd0 - range_reg;
            end
            CMD_DIV_STEP:
            begin
                dq_reg <= {dq_reg[30:0], 1'b0};
                if (rem_shift >= {1'b0, range_reg})
                begin
                    rem_reg <= 32'(rem_shift - {1'b0, range_reg});
                end
                else
                begin
                    rem_reg <= rem_shift[31:0];
                end
            end
            CMD_LOAD_OUT:
            begin
                case (ctrl.kind)
                    OUT_RAW:
                    begin
                        out_raw_reg <= rnd_reg;
                        out_bnd_reg <= '0;
                    end
                    OUT_FRAC:
                    begin
                        out_raw_reg <= rnd_reg >> 11;
                        out_bnd_reg <= '0;
                    end
                    default:
                    begin
                        out_raw_reg <= '0;
                        out_bnd_reg <= bnd_sum;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign stat.range_zero = (range_reg == 32'd0);
    assign stat.l_lt_range = (m_reg[31:0] < range_reg);
    assign stat.l_lt_thr   = (m_reg[31:0] < rem_reg);

    assign raw_or_fraction = out_raw_reg;
    assign bounded_value   = out_bnd_reg;

endmodule

>>> src/xrg_controller.sv
module xrg_controller
    import xrg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_op,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_stat_t   stat,
    output dp_ctrl_t   ctrl
);

    typedef enum logic [4:0] {
        S_IDLE, S_SEED, S_ADV, S_MA0, S_MA1, S_MA2, S_Z, S_MB0, S_MB1, S_MB2,
        S_STORE, S_DRAW, S_B_STEP, S_B_CHK, S_B_TEST, S_DIV, S_B_REJ, S_B_REMUL,
        S_J_CLR, S_JUMP, S_J_COPY, S_FINISH
    } state_t;

    state_t      state_reg;
    logic [7:0]  cnt_reg;
    logic [1:0]  word_reg;
    logic        far_reg;
    out_kind_t   kind_reg;
    logic        out_valid_reg;
    logic        load_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign load_out  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    always_comb
    begin
        ctrl.cmd     = CMD_NONE;
        ctrl.const_b = (state_reg == S_MB0) || (state_reg == S_MB1) || (state_reg == S_MB2);
        ctrl.acc_xor = (state_reg == S_JUMP) && poly_bit(far_reg, cnt_reg);
        ctrl.kind    = kind_reg;
        case (state_reg)
            S_IDLE:    ctrl.cmd = CMD_CAPTURE;
            S_SEED:    ctrl.cmd = CMD_SEED_LOAD;
            S_ADV:     ctrl.cmd = CMD_CTR_ADV;
            S_MA0:     ctrl.cmd = CMD_MUL_LL;
            S_MB0:     ctrl.cmd = CMD_MUL_LL;
            S_MA1:     ctrl.cmd = CMD_MUL_HL;
            S_MB1:     ctrl.cmd = CMD_MUL_HL;
            S_MA2:     ctrl.cmd = CMD_MUL_LH;
            S_MB2:     ctrl.cmd = CMD_MUL_LH;
            S_Z:       ctrl.cmd = CMD_Z_MIX;
            S_STORE:   ctrl.cmd = CMD_STORE;
            S_DRAW:    ctrl.cmd = CMD_STEP;
            S_B_STEP:  ctrl.cmd = CMD_STEP;
            S_JUMP:    ctrl.cmd = CMD_STEP;
            S_B_CHK:   ctrl.cmd = stat.range_zero ? CMD_NONE : CMD_BMUL;
            S_B_TEST:  ctrl.cmd = CMD_DIV_INIT;
            S_DIV:     ctrl.cmd = CMD_DIV_STEP;
            S_B_REJ:   ctrl.cmd = stat.l_lt_thr ? CMD_STEP : CMD_NONE;
            S_B_REMUL: ctrl.cmd = CMD_BMUL;
            S_J_CLR:   ctrl.cmd = CMD_ACC_CLR;
            S_J_COPY:  ctrl.cmd = CMD_ACC_COPY;
            S_FINISH:  ctrl.cmd = load_out ? CMD_LOAD_OUT : CMD_NONE;
            default:   ctrl.cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEED;
            cnt_reg       <= '0;
            word_reg      <= '0;
            far_reg       <= 1'b0;
            kind_reg      <= OUT_RAW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_op)
                            OP_RAW:
                            begin
                                kind_reg  <= OUT_RAW;
                                state_reg <= S_DRAW;
                            end
                            OP_FRAC:
                            begin
                                kind_reg  <= OUT_FRAC;
                                state_reg <= S_DRAW;
                            end
                            OP_BOUND:
                            begin
                                kind_reg  <= OUT_BND;
                                state_reg <= S_B_STEP;
                            end
                            OP_JUMP, OP_LJUMP:
                            begin
                                far_reg   <= (in_op == OP_LJUMP);
                                state_reg <= S_J_CLR;
                            end
                            OP_RESEED:
                            begin
                                state_reg <= S_SEED;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SEED:
                begin
                    word_reg  <= '0;
                    state_reg <= S_ADV;
                end
                S_ADV:   state_reg <= S_MA0;
                S_MA0:   state_reg <= S_MA1;
                S_MA1:   state_reg <= S_MA2;
                S_MA2:   state_reg <= S_Z;
                S_Z:     state_reg <= S_MB0;
                S_MB0:   state_reg <= S_MB1;
                S_MB1:   state_reg <= S_MB2;
                S_MB2:   state_reg <= S_STORE;
                S_STORE:
                begin
                    word_reg  <= word_reg + 2'd1;
                    state_reg <= (word_reg == 2'd3) ? S_IDLE : S_ADV;
                end
                S_DRAW:   state_reg <= S_FINISH;
                S_B_STEP: state_reg <= S_B_CHK;
                S_B_CHK:  state_reg <= stat.range_zero ? S_FINISH : S_B_TEST;
                S_B_TEST:
                begin
                    cnt_reg   <= '0;
                    state_reg <= stat.l_lt_range ? S_DIV : S_FINISH;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd31)
                    begin
                        state_reg <= S_B_REJ;
                    end
                end
                S_B_REJ:   state_reg <= stat.l_lt_thr ? S_B_REMUL : S_FINISH;
                S_B_REMUL: state_reg <= S_B_REJ;
                S_J_CLR:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_JUMP;
                end
                S_JUMP:
                begin
                    cnt_reg <= cnt_reg + 8'd1;
                    if (cnt_reg == 8'd255)
                    begin
                        state_reg <= S_J_COPY;
                    end
                end
                S_J_COPY: state_reg <= S_IDLE;
                S_FINISH:
                begin
                    if (load_out)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> src/xoshiro_random_generator_top.sv
// Pseudo-random generator with four 64-bit words, seeded by a splitmix64 expansion.
// The in_ch channel carries one operation per transaction: raw draw, bounded integer,
// Q0.53 fraction, jump, long jump or reseed. Draws return one transaction on out_ch;
// jumps and reseeds return none. The cfg_ch channel writes the 64-bit seed register,
// which is always ready and should be written only while the block is idle.
// The block works on one operation at a time; in_ch.ready is high only when idle.
// A raw or fraction draw takes a generator step, then loads the output register.
// A bounded draw takes a generator step and, unless the range is zero, a multiply by
// the range; when the first product falls low, the rejection threshold divider runs
// (one quotient bit per cycle), and each redraw adds a step and a multiply. A jump
// takes one generator step per polynomial bit. In a reseed, each word needs nine
// steps through one shared 32-bit multiplier. After reset the seed is zero and the
// block reseeds itself, so in_ch.ready rises only once that reseed is done.
// A finished result waits in an output register while the receiver stalls; the
// next operation is accepted meanwhile, and a new result waits until that one leaves.
module xoshiro_random_generator_top
    import xrg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    xrg_in_if.sink    in_ch,
    xrg_out_if.source out_ch,
    xrg_cfg_if.sink   cfg_ch
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg_ch.ready = 1'b1;

    xrg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.op),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    xrg_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .seed_we         (cfg_ch.valid),
        .seed_data       (cfg_ch.data),
        .low_bound       (in_ch.low_bound),
        .high_bound      (in_ch.high_bound),
        .stat            (stat),
        .raw_or_fraction (out_ch.raw_or_fraction),
        .bounded_value   (out_ch.bounded_value)
    );

endmodule

>>> src/xrg_checker.sv
module xrg_checker
    import xrg_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [2:0]  in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_raw,
    input logic [31:0] out_bnd
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Output transaction dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_raw) && $stable(out_bnd))
        else $error("Output payload changed while stalled.");

    a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_op <= OP_RESEED |=> !in_ready)
        else $error("Input accepted again while an operation is in progress.");

    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_raw == 64'd0 || out_bnd == 32'd0)
        else $error("Both result fields are nonzero.");

endmodule

bind xoshiro_random_generator_top xrg_checker u_xrg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_op     (in_ch.op),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_raw   (out_ch.raw_or_fraction),
    .out_bnd   (out_ch.bounded_value)
);

>>> test/tb.sv
module tb;
    import xrg_pkg::*;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] low_bound;
        logic signed [31:0] high_bound;
    } op_item_t;

    typedef struct {
        logic [63:0]        raw_or_fraction;
        logic signed [31:0] bounded_value;
    } draw_result_t;

    logic clk;
    logic rst_n;

    xrg_in_if  in_ch();
    xrg_out_if out_ch();
    xrg_cfg_if cfg_ch();

    xoshiro_random_generator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    op_item_t     pending_ops[$];
    draw_result_t expected_draws[$];
    logic [63:0]  gen_words[4];
    logic [63:0]  seed_reg;
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    longint       cycle_count;
    logic         driver_busy;
    logic         in_taken;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
        return (v << k) | (v >> (64 - k));
    endfunction

    function automatic logic [63:0] mix_draw(inout logic [63:0] ctr);
        logic [63:0] z;
        ctr = ctr + GOLDEN_GAMMA;
        z = ctr;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    task automatic expand_seed_words(input logic [63:0] s);
        logic [63:0] ctr;
        ctr = s;
        for (int i = 0; i < 4; i++)
            gen_words[i] = mix_draw(ctr);
    endtask

    task automatic advance_words(output logic [63:0] r);
        logic [63:0] t;
        r = rotl64(gen_words[0] + gen_words[3], 23) + gen_words[0];
        t = gen_words[1] << 17;
        gen_words[2] ^= gen_words[0];
        gen_words[3] ^= gen_words[1];
        gen_words[1] ^= gen_words[2];
        gen_words[0] ^= gen_words[3];
        gen_words[2] ^= t;
        gen_words[3] = rotl64(gen_words[3], 45);
    endtask

    task automatic jump_words(input logic [255:0] poly);
        logic [63:0] acc[4];
        logic [63:0] dummy;
        for (int k = 0; k < 4; k++)
            acc[k] = '0;
        for (int b = 0; b < 256; b++)
        begin
            if (poly[b])
                for (int k = 0; k < 4; k++)
                    acc[k] ^= gen_words[k];
            advance_words(dummy);
        end
        for (int k = 0; k < 4; k++)
            gen_words[k] = acc[k];
    endtask

    task automatic bounded_pick(input logic [31:0] lo, input logic [31:0] hi,
                                output logic [31:0] v);
        logic [31:0] range;
        logic [31:0] thr;
        logic [63:0] r;
        logic [63:0] m;
        range = hi - lo + 32'd1;
        advance_words(r);
        if (range == 32'd0)
        begin
            v = lo + r[63:32];
            return;
        end
        m = {32'd0, r[63:32]} * {32'd0, range};
        if (m[31:0] < range)
        begin
            thr = (32'd0 - range) % range;
            while (m[31:0] < thr)
            begin
                advance_words(r);
                m = {32'd0, r[63:32]} * {32'd0, range};
            end
        end
        v = lo + m[63:32];
    endtask

    task automatic predict_op(input op_item_t it);
        draw_result_t e;
        logic [63:0]  r;
        logic [31:0]  v;
        e.raw_or_fraction = '0;
        e.bounded_value = '0;
        case (it.op)
            OP_RAW:
            begin
                advance_words(r);
                e.raw_or_fraction = r;
                expected_draws.push_back(e);
            end
            OP_BOUND:
            begin
                bounded_pick(it.low_bound, it.high_bound, v);
                e.bounded_value = v;
                expected_draws.push_back(e);
            end
            OP_FRAC:
            begin
                advance_words(r);
                e.raw_or_fraction = r >> 11;
                expected_draws.push_back(e);
            end
            OP_JUMP: jump_words(SHORT_JUMP_POLY);
            OP_LJUMP: jump_words(FAR_JUMP_POLY);
            OP_RESEED: expand_seed_words(seed_reg);
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            driver_busy <= 1'b0;
        end
        else if (!(in_ch.valid && !in_taken))
        begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                op_item_t it;
                it = pending_ops.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.op         <= it.op;
                in_ch.low_bound  <= it.low_bound;
                in_ch.high_bound <= it.high_bound;
                driver_busy      <= 1'b1;
            end
            else
            begin
                in_ch.valid <= 1'b0;
                driver_busy <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        in_taken <= in_ch.valid && in_ch.ready;
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (in_ch.valid && in_ch.ready)
            begin
                op_item_t it;
                it.op = in_ch.op;
                it.low_bound = in_ch.low_bound;
                it.high_bound = in_ch.high_bound;
                predict_op(it);
            end
            if (cfg_ch.valid && cfg_ch.ready)
                seed_reg = cfg_ch.data;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_draws.size() == 0)
                    report_mismatch("unexpected result transaction");
                else
                begin
                    draw_result_t e;
                    e = expected_draws.pop_front();
                    if (out_ch.raw_or_fraction !== e.raw_or_fraction)
                        report_mismatch($sformatf("raw_or_fraction %h, expected %h",
                            out_ch.raw_or_fraction, e.raw_or_fraction));
                    if (out_ch.bounded_value !== e.bounded_value)
                        report_mismatch($sformatf("bounded_value %0d, expected %0d",
                            out_ch.bounded_value, e.bounded_value));
                end
            end
            if (cycle_count > 4000000)
            begin
                $display("timeout");
                $display("xoshiro_random_generator_top: mismatch");
                $finish;
            end
        end
    end

    task automatic add_op(input logic [2:0] op, input logic [31:0] lo,
                          input logic [31:0] hi);
        op_item_t it;
        it.op = op;
        it.low_bound = lo;
        it.high_bound = hi;
        pending_ops.push_back(it);
    endtask

    task automatic drain();
        while (pending_ops.size() > 0 || in_ch.valid || driver_busy
               || expected_draws.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_seed(input logic [63:0] s);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= s;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_random_ops(input int n);
        logic [31:0] lo;
        logic [31:0] hi;
        int          sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            lo = $urandom;
            hi = $urandom;
            case ($urandom_range(3))
                0: hi = lo + $urandom_range(20);
                1: hi = lo + ($urandom >> $urandom_range(31));
                default: ;
            endcase
            if (sel < 30)
                add_op(OP_RAW, lo, hi);
            else if (sel < 70)
                add_op(OP_BOUND, lo, hi);
            else if (sel < 90)
                add_op(OP_FRAC, lo, hi);
            else if (sel < 93)
                add_op(OP_JUMP, lo, hi);
            else if (sel < 95)
                add_op(OP_LJUMP, lo, hi);
            else if (sel < 98)
                add_op(OP_RESEED, lo, hi);
            else
                add_op(3'($urandom_range(6, 7)), lo, hi);
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        seed_reg = '0;
        expand_seed_words('0);
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_RAW;
        in_ch.low_bound = '0;
        in_ch.high_bound = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        driver_busy = 1'b0;
        in_taken = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_op(OP_RAW, 0, 0);
        add_op(OP_FRAC, 0, 0);
        add_op(OP_BOUND, 0, 0);
        add_op(OP_BOUND, 32'h80000000, 32'h7fffffff);
        add_op(OP_BOUND, 32'h7fffffff, 32'h7fffffff);
        add_op(OP_BOUND, 32'h80000000, 32'h80000000);
        add_op(OP_BOUND, 5, -5);
        add_op(OP_BOUND, 0, 32'h80000000);
        add_op(OP_BOUND, -3, 2);
        add_op(OP_BOUND, 0, 32'h40000000);
        add_op(OP_JUMP, 0, 0);
        add_op(OP_RAW, 32'hffffffff, 32'hffffffff);
        add_op(OP_LJUMP, 0, 0);
        add_op(OP_FRAC, 0, 0);
        add_op(3'd6, 0, 0);
        add_op(3'd7, 32'hffffffff, 32'hffffffff);
        add_op(OP_RESEED, 0, 0);
        add_op(OP_RAW, 0, 0);
        drain();

        write_seed(64'hffffffffffffffff);
        add_op(OP_RESEED, 0, 0);
        add_op(OP_RAW, 0, 0);
        add_random_ops(150);
        drain();

        send_idle_pct = 75;
        write_seed({$urandom, $urandom});
        add_op(OP_RESEED, 0, 0);
        add_random_ops(200);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 75;
        write_seed(64'd1);
        add_op(OP_RESEED, 0, 0);
        add_random_ops(200);
        drain();

        send_idle_pct = 7;
        recv_stall_pct = 7;
        write_seed({$urandom, $urandom});
        add_random_ops(200);
        drain();

        if (error_count == 0)
            $display("xoshiro_random_generator_top: match");
        else
            $display("xoshiro_random_generator_top: mismatch");
        $finish;
    end
endmodule
